[hdl/cbf_pkg.sv]
// ----------------------------------------------------------------------------
// cbf_pkg: shared types and constants for the capsule broad-phase filter
// Field widths, stream packing, register codes and wide-arithmetic widths.
// ----------------------------------------------------------------------------
package cbf_pkg;

  localparam int COORD_W         = 32;  // signed Q16.16 coordinate
  localparam int RAD_W           = 31;  // unsigned Q15.16 radius
  localparam int IDX_W           = 16;  // triangle index
  localparam int COORD_FRAC_BITS = 16;
  localparam int CFG_W           = 32;
  localparam int CFG_IDX_W       = 3;

  localparam int IN_TDATA_W  = ((3 * COORD_W + IDX_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((IDX_W + 7) / 8) * 8;

  // Wide-arithmetic widths
  localparam int MAG_W  = COORD_W;     // |a - b| of two coordinates
  localparam int SQ_W   = 2 * MAG_W;   // one squared or cross term
  localparam int SUM_W  = SQ_W + 2;    // sum of three terms
  localparam int HALF_W = SUM_W / 2;   // operand half for split multiplies
  localparam int PP_W   = 2 * HALF_W;  // one partial product
  localparam int PROD_W = 2 * SUM_W;   // full product
  localparam int CMP_W  = PROD_W + 1;  // product sum

  // Segments with squared length below 1e-6 collapse to their start point
  localparam logic [SUM_W-1:0] SHORT_THR =
    SUM_W'(((64'd1 << (2 * COORD_FRAC_BITS)) + 64'd999999) / 64'd1000000);

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec3_t;

  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic             last;
  } side_t;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MESH_RADIUS  = 3'd0,
    REG_PROBE_RADIUS = 3'd1,
    REG_START_X      = 3'd2,
    REG_START_Y      = 3'd3,
    REG_START_Z      = 3'd4,
    REG_END_X        = 3'd5,
    REG_END_Y        = 3'd6,
    REG_END_Z        = 3'd7
  } cfg_reg_t;

endpackage

[hdl/capsule_broadphase_filter.sv]
// ----------------------------------------------------------------------------
// capsule_broadphase_filter: swept-sphere broad-phase triangle cull
// Keeps a triangle when the mesh bound touches the capsule and the centroid
// lies strictly inside the capsule widened by the mesh radius.
// ----------------------------------------------------------------------------
// Path: an input transfer passes through the eight compare stages and then
//   the output register before its result transfer.
// Throughput: one triangle per cycle while the output is not stalled; the
//   eight-stage compare pipeline and the output register each advance
//   independently, so bubbles fill behind a stalled result.
// Reset: synchronous, active low; clears all valid bits and sets every
//   configuration register to zero.
// ----------------------------------------------------------------------------
module capsule_broadphase_filter (
  input  logic                             clk,
  input  logic                             rst_n,
  // configuration write port
  input  logic                             cfg_wr_en,
  input  logic [cbf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbf_pkg::CFG_W-1:0]        cfg_wdata,
  // triangle stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // tdata: centroid_x, centroid_y, centroid_z, tri_index (from bit 0 up)
  input  logic [cbf_pkg::IN_TDATA_W-1:0]   in_tdata,
  input  logic                             in_tlast,   // last_tri
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // tdata: kept_index (from bit 0 up)
  output logic [cbf_pkg::OUT_TDATA_W-1:0]  out_tdata,
  output logic                             out_tuser,  // tuser: kept
  output logic                             out_tlast   // last_result
);
  import cbf_pkg::*;

  // Configuration registers
  logic [RAD_W-1:0] mesh_radius_r;
  logic [RAD_W-1:0] probe_radius_r;
  vec3_t            start_r;
  vec3_t            end_r;

  // Pipeline connections
  vec3_t            in_point;
  side_t            in_side;
  logic             item_in_ready;
  logic             item_out_valid;
  cmp_t             item_res;
  side_t            item_side;
  logic             mesh_out_valid;
  cmp_t             mesh_res;

  // Output register
  logic             out_adv;
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic             out_kept_r;
  logic             out_last_r;
  logic             kept_nxt;

  // Take writes; user must change config only with no triangle in flight; unenforced
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mesh_radius_r  <= '0;
      probe_radius_r <= '0;
      start_r        <= '0;
      end_r          <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_MESH_RADIUS:  mesh_radius_r  <= cfg_wdata[RAD_W-1:0];
        REG_PROBE_RADIUS: probe_radius_r <= cfg_wdata[RAD_W-1:0];
        REG_START_X:      start_r.x      <= $signed(cfg_wdata[COORD_W-1:0]);
        REG_START_Y:      start_r.y      <= $signed(cfg_wdata[COORD_W-1:0]);
        REG_START_Z:      start_r.z      <= $signed(cfg_wdata[COORD_W-1:0]);
        REG_END_X:        end_r.x        <= $signed(cfg_wdata[COORD_W-1:0]);
        REG_END_Y:        end_r.y        <= $signed(cfg_wdata[COORD_W-1:0]);
        REG_END_Z:        end_r.z        <= $signed(cfg_wdata[COORD_W-1:0]);
      endcase
    end
  end

  // Unpack the input transfer
  assign in_point.x    = $signed(in_tdata[COORD_W-1:0]);
  assign in_point.y    = $signed(in_tdata[2*COORD_W-1:COORD_W]);
  assign in_point.z    = $signed(in_tdata[3*COORD_W-1:2*COORD_W]);
  assign in_side.idx   = in_tdata[3*COORD_W+IDX_W-1:3*COORD_W];
  assign in_side.last  = in_tlast;

  // Centroid lane: one triangle per transfer, stalls with the output
  cbf_seg_cmp u_item (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (item_in_ready),
    .point     (in_point),
    .seg_start (start_r),
    .seg_end   (end_r),
    .radius_a  (mesh_radius_r),
    .radius_b  (probe_radius_r),
    .side_in   (in_side),
    .out_valid (item_out_valid),
    .out_ready (out_adv),
    .result    (item_res),
    .side_out  (item_side)
  );

  // Mesh lane: origin against the capsule, free running on the registers.
  // Its output matches what a triangle leaving the centroid lane was sampled
  // with only if the configuration is unchanged while triangles are in flight.
  cbf_seg_cmp u_mesh (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (1'b1),
    .in_ready  (),
    .point     ('0),
    .seg_start (start_r),
    .seg_end   (end_r),
    .radius_a  (mesh_radius_r),
    .radius_b  (probe_radius_r),
    .side_in   ('0),
    .out_valid (mesh_out_valid),
    .out_ready (1'b1),
    .result    (mesh_res),
    .side_out  ()
  );

  assign in_tready = item_in_ready;

  // Mesh bound touches (<=), centroid strictly inside (<)
  assign kept_nxt = (mesh_res.lt || mesh_res.eq) && item_res.lt;

  // Output register: advance when empty or when the current result transfers
  assign out_adv = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= item_out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      out_idx_r  <= item_side.idx;
      out_kept_r <= kept_nxt;
      out_last_r <= item_side.last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'(out_idx_r);
  assign out_tuser  = out_kept_r;
  assign out_tlast  = out_last_r;

  // The lane only refuses input when a result is held at the output
  a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
    !item_in_ready |-> (out_valid_r && !out_tready))
    else $error("input stalled without a held result");

  // Once filled, the mesh lane stays valid
  a_mesh_stays_valid: assert property (@(posedge clk) disable iff (!rst_n)
    mesh_out_valid |=> mesh_out_valid)
    else $error("mesh lane lost its valid result");

  // A finished triangle always finds a valid mesh result beside it
  a_mesh_before_item: assert property (@(posedge clk) disable iff (!rst_n)
    item_out_valid |-> mesh_out_valid)
    else $error("triangle result ahead of mesh result");

endmodule

[hdl/cbf_seg_cmp.sv]
// ----------------------------------------------------------------------------
// cbf_seg_cmp: point-to-segment squared distance versus (ra + rb)^2
// Eight-stage pipeline with per-stage valid bits; compares exactly by
// cross-multiplication in wide integers.
// ----------------------------------------------------------------------------
module cbf_seg_cmp (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  cbf_pkg::vec3_t           point,
  input  cbf_pkg::vec3_t           seg_start,
  input  cbf_pkg::vec3_t           seg_end,
  input  logic [cbf_pkg::RAD_W-1:0] radius_a,
  input  logic [cbf_pkg::RAD_W-1:0] radius_b,
  input  cbf_pkg::side_t           side_in,
  output logic                     out_valid,
  input  logic                     out_ready,
  output cbf_pkg::cmp_t            result,
  output cbf_pkg::side_t           side_out
);
  import cbf_pkg::*;

  localparam int NSTAGE = 8;

  typedef enum logic [1:0] {
    NEAR_START,
    NEAR_END,
    NEAR_MID
  } near_t;

  typedef struct packed {
    logic [PP_W-1:0] hh;
    logic [PP_W-1:0] hl;
    logic [PP_W-1:0] lh;
    logic [PP_W-1:0] ll;
  } pp_t;

  // sign of a - b on top, magnitude below
  function automatic logic [MAG_W:0] abs_diff(coord_t a, coord_t b);
    logic [MAG_W:0] d;
    logic [MAG_W:0] r;
    d = {a[COORD_W-1], a} - {b[COORD_W-1], b};
    r[MAG_W] = d[MAG_W];
    r[MAG_W-1:0] = d[MAG_W] ? MAG_W'(-d) : d[MAG_W-1:0];
    return r;
  endfunction

  // magnitude of a - b only
  function automatic logic [MAG_W-1:0] abs_mag(coord_t a, coord_t b);
    logic [MAG_W:0] r;
    r = abs_diff(a, b);
    return r[MAG_W-1:0];
  endfunction

  function automatic cmp_t cmp_wide(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    cmp_t r;
    r.lt = (a < b);
    r.eq = (a == b);
    return r;
  endfunction

  function automatic pp_t split_mul(logic [SUM_W-1:0] a, logic [SUM_W-1:0] b);
    pp_t r;
    r.hh = PP_W'(a[SUM_W-1:HALF_W]) * PP_W'(b[SUM_W-1:HALF_W]);
    r.hl = PP_W'(a[SUM_W-1:HALF_W]) * PP_W'(b[HALF_W-1:0]);
    r.lh = PP_W'(a[HALF_W-1:0]) * PP_W'(b[SUM_W-1:HALF_W]);
    r.ll = PP_W'(a[HALF_W-1:0]) * PP_W'(b[HALF_W-1:0]);
    return r;
  endfunction

  function automatic logic [PROD_W-1:0] join_pp(pp_t p);
    return (PROD_W'(p.hh) << (2 * HALF_W)) + (PROD_W'(p.hl) << HALF_W)
         + (PROD_W'(p.lh) << HALF_W) + PROD_W'(p.ll);
  endfunction

  logic [NSTAGE-1:0] valid_r;
  logic [NSTAGE-1:0] valid_nxt;
  logic [NSTAGE-1:0] adv;
  side_t             side_r [NSTAGE];

  logic [MAG_W:0]    u_ad [3];
  logic [MAG_W:0]    d_ad [3];
  logic [MAG_W-1:0]  v_mag [3];

  // stage 1: differences and magnitudes
  logic [MAG_W-1:0]  s1_umag_r [3];
  logic              s1_usgn_r [3];
  logic [MAG_W-1:0]  s1_dmag_r [3];
  logic              s1_dsgn_r [3];
  logic [MAG_W-1:0]  s1_vmag_r [3];
  logic [RAD_W:0]    s1_t_r;
  // stage 2: squares and cross terms
  logic [SQ_W-1:0]   s2_usq_r [3];
  logic [SQ_W-1:0]   s2_dsq_r [3];
  logic [SQ_W-1:0]   s2_vsq_r [3];
  logic [SQ_W-1:0]   s2_ud_r [3];
  logic              s2_udneg_r [3];
  logic [SQ_W-1:0]   s2_tsq_r;
  // stage 3: sums
  logic [SUM_W-1:0]  s3_usq_r;
  logic [SUM_W-1:0]  s3_len_r;
  logic [SUM_W-1:0]  s3_vsq_r;
  logic [SUM_W-1:0]  s3_pos_r;
  logic [SUM_W-1:0]  s3_neg_r;
  logic [SQ_W-1:0]   s3_tsq_r;
  // stage 4: region select and end-point compares
  near_t             s4_near_r;
  logic [SUM_W-1:0]  s4_dot_r;
  cmp_t              s4_cmpu_r;
  cmp_t              s4_cmpv_r;
  logic [SUM_W-1:0]  s4_usq_r;
  logic [SUM_W-1:0]  s4_len_r;
  logic [SQ_W-1:0]   s4_tsq_r;
  // stage 5: partial products
  pp_t               s5_pp_r [3];
  near_t             s5_near_r;
  cmp_t              s5_cmpu_r;
  cmp_t              s5_cmpv_r;
  // stage 6: full products
  logic [PROD_W-1:0] s6_prod_r [3];
  near_t             s6_near_r;
  cmp_t              s6_cmpu_r;
  cmp_t              s6_cmpv_r;
  // stage 7: both sides of the interior compare
  logic [CMP_W-1:0]  s7_lhs_r;
  logic [CMP_W-1:0]  s7_rhs_r;
  near_t             s7_near_r;
  cmp_t              s7_cmpu_r;
  cmp_t              s7_cmpv_r;
  // stage 8: result
  cmp_t              s8_res_r;

  // advance a stage when it is empty or the stage after it advances
  always_comb begin
    adv[NSTAGE-1] = !valid_r[NSTAGE-1] || out_ready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !valid_r[k] || adv[k+1];
    end
  end

  assign valid_nxt = (adv & {valid_r[NSTAGE-2:0], in_valid}) | (~adv & valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  assign u_ad[0]  = abs_diff(point.x, seg_start.x);
  assign u_ad[1]  = abs_diff(point.y, seg_start.y);
  assign u_ad[2]  = abs_diff(point.z, seg_start.z);
  assign d_ad[0]  = abs_diff(seg_end.x, seg_start.x);
  assign d_ad[1]  = abs_diff(seg_end.y, seg_start.y);
  assign d_ad[2]  = abs_diff(seg_end.z, seg_start.z);
  assign v_mag[0] = abs_mag(point.x, seg_end.x);
  assign v_mag[1] = abs_mag(point.y, seg_end.y);
  assign v_mag[2] = abs_mag(point.z, seg_end.z);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      for (int i = 0; i < 3; i++) begin
        s1_umag_r[i] <= u_ad[i][MAG_W-1:0];
        s1_usgn_r[i] <= u_ad[i][MAG_W];
        s1_dmag_r[i] <= d_ad[i][MAG_W-1:0];
        s1_dsgn_r[i] <= d_ad[i][MAG_W];
        s1_vmag_r[i] <= v_mag[i];
      end
      s1_t_r       <= {1'b0, radius_a} + {1'b0, radius_b};
      side_r[0]    <= side_in;
    end
    if (adv[1]) begin
      for (int i = 0; i < 3; i++) begin
        s2_usq_r[i]   <= SQ_W'(s1_umag_r[i]) * SQ_W'(s1_umag_r[i]);
        s2_dsq_r[i]   <= SQ_W'(s1_dmag_r[i]) * SQ_W'(s1_dmag_r[i]);
        s2_vsq_r[i]   <= SQ_W'(s1_vmag_r[i]) * SQ_W'(s1_vmag_r[i]);
        s2_ud_r[i]    <= SQ_W'(s1_umag_r[i]) * SQ_W'(s1_dmag_r[i]);
        s2_udneg_r[i] <= s1_usgn_r[i] ^ s1_dsgn_r[i];
      end
      s2_tsq_r  <= SQ_W'(s1_t_r) * SQ_W'(s1_t_r);
      side_r[1] <= side_r[0];
    end
    if (adv[2]) begin
      s3_usq_r <= SUM_W'(s2_usq_r[0]) + SUM_W'(s2_usq_r[1]) + SUM_W'(s2_usq_r[2]);
      s3_len_r <= SUM_W'(s2_dsq_r[0]) + SUM_W'(s2_dsq_r[1]) + SUM_W'(s2_dsq_r[2]);
      s3_vsq_r <= SUM_W'(s2_vsq_r[0]) + SUM_W'(s2_vsq_r[1]) + SUM_W'(s2_vsq_r[2]);
      s3_pos_r <= (s2_udneg_r[0] ? '0 : SUM_W'(s2_ud_r[0]))
                + (s2_udneg_r[1] ? '0 : SUM_W'(s2_ud_r[1]))
                + (s2_udneg_r[2] ? '0 : SUM_W'(s2_ud_r[2]));
      s3_neg_r <= (s2_udneg_r[0] ? SUM_W'(s2_ud_r[0]) : '0)
                + (s2_udneg_r[1] ? SUM_W'(s2_ud_r[1]) : '0)
                + (s2_udneg_r[2] ? SUM_W'(s2_ud_r[2]) : '0);
      s3_tsq_r <= s2_tsq_r;
      side_r[2] <= side_r[1];
    end
    if (adv[3]) begin
      // short segment or projection before the start: nearest point is start
      if ((s3_len_r < SHORT_THR) || (s3_pos_r <= s3_neg_r)) begin
        s4_near_r <= NEAR_START;
      end else if ({1'b0, s3_pos_r} >= ({1'b0, s3_neg_r} + {1'b0, s3_len_r})) begin
        s4_near_r <= NEAR_END;
      end else begin
        s4_near_r <= NEAR_MID;
      end
      s4_dot_r  <= s3_pos_r - s3_neg_r;
      s4_cmpu_r <= cmp_wide(s3_usq_r, SUM_W'(s3_tsq_r));
      s4_cmpv_r <= cmp_wide(s3_vsq_r, SUM_W'(s3_tsq_r));
      s4_usq_r  <= s3_usq_r;
      s4_len_r  <= s3_len_r;
      s4_tsq_r  <= s3_tsq_r;
      side_r[3] <= side_r[2];
    end
    if (adv[4]) begin
      s5_pp_r[0] <= split_mul(s4_usq_r, s4_len_r);
      s5_pp_r[1] <= split_mul(s4_dot_r, s4_dot_r);
      s5_pp_r[2] <= split_mul(SUM_W'(s4_tsq_r), s4_len_r);
      s5_near_r  <= s4_near_r;
      s5_cmpu_r  <= s4_cmpu_r;
      s5_cmpv_r  <= s4_cmpv_r;
      side_r[4]  <= side_r[3];
    end
    if (adv[5]) begin
      for (int i = 0; i < 3; i++) begin
        s6_prod_r[i] <= join_pp(s5_pp_r[i]);
      end
      s6_near_r <= s5_near_r;
      s6_cmpu_r <= s5_cmpu_r;
      s6_cmpv_r <= s5_cmpv_r;
      side_r[5] <= side_r[4];
    end
    if (adv[6]) begin
      // |u|^2 L - k^2 < T^2 L  <=>  |u|^2 L < T^2 L + k^2
      s7_lhs_r  <= CMP_W'(s6_prod_r[0]);
      s7_rhs_r  <= CMP_W'(s6_prod_r[2]) + CMP_W'(s6_prod_r[1]);
      s7_near_r <= s6_near_r;
      s7_cmpu_r <= s6_cmpu_r;
      s7_cmpv_r <= s6_cmpv_r;
      side_r[6] <= side_r[5];
    end
    if (adv[7]) begin
      case (s7_near_r)
        NEAR_START: s8_res_r <= s7_cmpu_r;
        NEAR_END:   s8_res_r <= s7_cmpv_r;
        default: begin
          s8_res_r.lt <= (s7_lhs_r < s7_rhs_r);
          s8_res_r.eq <= (s7_lhs_r == s7_rhs_r);
        end
      endcase
      side_r[7] <= side_r[6];
    end
  end

  assign in_ready  = adv[0];
  assign out_valid = valid_r[NSTAGE-1];
  assign result    = s8_res_r;
  assign side_out  = side_r[NSTAGE-1];

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the capsule broad-phase filter
// Streams triangle centroids against a series of capsule queries and checks
// every keep/drop verdict against an exact wide-integer distance predictor,
// under random gaps on the sender, random stalls on the receiver, a long
// receiver hold-off and stretches at full rate.
// ----------------------------------------------------------------------------
module testbench;
  import cbf_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int LONG_HOLD   = 300;   // receiver hold-off, in cycles
  localparam int SETTLE      = 24;    // cycles to wait out the pipeline

  // Sign-extended point and wide products used by the distance predictor
  typedef logic [2:0][63:0] pt3_t;
  typedef logic [143:0]     wide_t;

  // Segments whose squared length is below 1e-6 collapse to the start point
  localparam wide_t SHORT_LEN = ((wide_t'(1) << 32) + 999999) / 1000000;

  typedef struct {
    logic [IDX_W-1:0] idx;
    logic             kept;
    logic             last;
  } verdict_t;

  logic clk;
  logic rst_n;

  logic                   cfg_wr_en;
  logic [CFG_IDX_W-1:0]   cfg_index;
  logic [CFG_W-1:0]       cfg_wdata;

  logic                   in_tvalid;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata;   // centroid_x, centroid_y, centroid_z, tri_index
  logic                   in_tlast;   // last_tri

  logic                   out_tvalid;
  logic                   out_tready;
  logic [OUT_TDATA_W-1:0] out_tdata;  // kept_index
  logic                   out_tuser;  // kept
  logic                   out_tlast;  // last_result

  capsule_broadphase_filter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // Local copy of the query registers, updated on every write
  logic [RAD_W-1:0]  mesh_r;
  logic [RAD_W-1:0]  probe_r;
  logic [2:0][31:0]  seg_s;
  logic [2:0][31:0]  seg_e;

  verdict_t verdict_q[$];   // verdicts still owed by the block
  verdict_t got_v;
  int       mismatch_count;
  int       cycle_count;

  // Flow control knobs for the sender and the receiver
  bit tx_gaps_on;
  bit rx_stalls_on;
  int hold_token;
  int hold_seen;
  int rx_stall_left;

  // --------------------------------------------------------------------------
  // Clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Distance predictor
  // --------------------------------------------------------------------------
  function automatic logic [63:0] widen(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  function automatic logic [32:0] axis_mag(longint d);
    return (d < 0) ? 33'(-d) : 33'(d);
  endfunction

  function automatic wide_t sq_len(pt3_t a, pt3_t b);
    wide_t       acc;
    logic [32:0] m;
    int          i;
    acc = '0;
    for (i = 0; i < 3; i++) begin
      m = axis_mag(longint'($signed(a[i])) - longint'($signed(b[i])));
      acc = acc + wide_t'(m) * wide_t'(m);
    end
    return acc;
  endfunction

  function automatic int order3(wide_t a, wide_t b);
    return (a < b) ? -1 : ((a == b) ? 0 : 1);
  endfunction

  // Sign of (squared distance from p to segment s..e) minus tsq, with the
  // segment parameter clamp and the division replaced by cross-multiplying.
  function automatic int capsule_gap(pt3_t p, pt3_t s, pt3_t e, logic [63:0] tsq);
    wide_t  len, usq, t2, pos, neg, dot, prod;
    longint u, d;
    int     i;
    len = sq_len(e, s);
    usq = sq_len(p, s);
    t2  = wide_t'(tsq);
    if (len < SHORT_LEN) return order3(usq, t2);
    pos = '0;
    neg = '0;
    for (i = 0; i < 3; i++) begin
      u = longint'($signed(p[i])) - longint'($signed(s[i]));
      d = longint'($signed(e[i])) - longint'($signed(s[i]));
      prod = wide_t'(axis_mag(u)) * wide_t'(axis_mag(d));
      if ((u < 0) != (d < 0)) neg = neg + prod;
      else pos = pos + prod;
    end
    // nearest point is the start, the end, or somewhere in between
    if (pos <= neg) return order3(usq, t2);
    if (pos >= neg + len) return order3(sq_len(p, e), t2);
    dot = pos - neg;
    return order3(usq * len - dot * dot, t2 * len);
  endfunction

  function automatic logic triangle_kept(logic [31:0] cx, logic [31:0] cy,
                                         logic [31:0] cz);
    pt3_t        p, s, e, orig;
    logic [63:0] t, tsq;
    int          i;
    for (i = 0; i < 3; i++) begin
      s[i] = widen(seg_s[i]);
      e[i] = widen(seg_e[i]);
    end
    p[0] = widen(cx);
    p[1] = widen(cy);
    p[2] = widen(cz);
    orig = '0;
    t    = 64'(mesh_r) + 64'(probe_r);
    tsq  = t * t;
    // the mesh bound may touch the capsule; the centroid must be strictly in
    return (capsule_gap(orig, s, e, tsq) <= 0) && (capsule_gap(p, s, e, tsq) < 0);
  endfunction

  // --------------------------------------------------------------------------
  // Gap lengths: mostly none or short, now and then long
  // --------------------------------------------------------------------------
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(25, 70);
  endfunction

  // --------------------------------------------------------------------------
  // Receiver: random stalls, plus a long hold-off whenever the token moves
  // --------------------------------------------------------------------------
  initial begin
    out_tready <= 1'b0;
    rx_stall_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_token != hold_seen) begin
        hold_seen = hold_token;
        rx_stall_left = LONG_HOLD;
      end
      if (rx_stall_left > 0) begin
        out_tready <= 1'b0;
        rx_stall_left--;
      end else begin
        out_tready <= 1'b1;
        if (rx_stalls_on && $urandom_range(0, 3) == 0) rx_stall_left = pick_gap();
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result checker: compare each transfer with the oldest verdict owed
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (verdict_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected result at cycle %0d: index %h kept %b last %b",
                   cycle_count, out_tdata[IDX_W-1:0], out_tuser, out_tlast);
      end else begin
        got_v = verdict_q.pop_front();
        if (out_tdata[IDX_W-1:0] !== got_v.idx || out_tuser !== got_v.kept ||
            out_tlast !== got_v.last) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("mismatch at cycle %0d: index %h/%h kept %b/%b last %b/%b (exp/got)",
                     cycle_count, got_v.idx, out_tdata[IDX_W-1:0], got_v.kept,
                     out_tuser, got_v.last, out_tlast);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Configuration writes: one register per cycle, mirrored locally
  // --------------------------------------------------------------------------
  task automatic write_reg(cfg_reg_t which, logic [31:0] value);
    cfg_wr_en <= 1'b1;
    cfg_index <= which;
    cfg_wdata <= value;
    @(posedge clk);
    case (which)
      REG_MESH_RADIUS:  mesh_r = value[RAD_W-1:0];
      REG_PROBE_RADIUS: probe_r = value[RAD_W-1:0];
      REG_START_X:      seg_s[0] = value;
      REG_START_Y:      seg_s[1] = value;
      REG_START_Z:      seg_s[2] = value;
      REG_END_X:        seg_e[0] = value;
      REG_END_Y:        seg_e[1] = value;
      REG_END_Z:        seg_e[2] = value;
      default: ;
    endcase
  endtask

  task automatic load_query(logic [31:0] rm, logic [31:0] rp,
                            logic [31:0] sx, logic [31:0] sy, logic [31:0] sz,
                            logic [31:0] ex, logic [31:0] ey, logic [31:0] ez);
    write_reg(REG_MESH_RADIUS, rm);
    write_reg(REG_PROBE_RADIUS, rp);
    write_reg(REG_START_X, sx);
    write_reg(REG_START_Y, sy);
    write_reg(REG_START_Z, sz);
    write_reg(REG_END_X, ex);
    write_reg(REG_END_Y, ey);
    write_reg(REG_END_Z, ez);
    cfg_wr_en <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Sender: offer one triangle, hold it until the transfer, log its verdict
  // --------------------------------------------------------------------------
  task automatic send_triangle(logic [31:0] cx, logic [31:0] cy, logic [31:0] cz,
                               logic [IDX_W-1:0] idx, logic last);
    int       gap;
    verdict_t v;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {idx, cz, cy, cx};
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    v.idx  = idx;
    v.kept = triangle_kept(cx, cy, cz);
    v.last = last;
    verdict_q.insert(verdict_q.size(), v);
  endtask

  // Drop valid and hold until every owed verdict has come back
  task automatic wait_results_done();
    in_tvalid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random queries and centroids
  // --------------------------------------------------------------------------
  function automatic logic [31:0] rand_coord(bit full_range);
    if (full_range) return $urandom;
    return 32'($urandom_range(0, 32'h200000)) - 32'h100000;
  endfunction

  function automatic logic [31:0] rand_radius();
    if ($urandom_range(0, 5) == 0) return $urandom;
    // set the top bit now and then; the block must drop it
    return 32'($urandom_range(0, 32'h60000)) | {1'($urandom_range(0, 1)), 31'b0};
  endfunction

  task automatic randomize_query();
    logic [2:0][31:0] s, e;
    int               shape, i;
    bit               full_range;
    shape = $urandom_range(0, 9);
    full_range = (shape == 0);
    for (i = 0; i < 3; i++) begin
      s[i] = rand_coord(full_range);
      case (shape)
        1:       e[i] = s[i] + 32'($urandom_range(0, 140)) - 32'd70;  // near-degenerate
        2:       e[i] = s[i];                                          // zero length
        default: e[i] = rand_coord(full_range);
      endcase
    end
    load_query(rand_radius(), rand_radius(), s[0], s[1], s[2], e[0], e[1], e[2]);
  endtask

  // Scatter a point around the start, the end or the middle of the axis, now and then anywhere
  task automatic near_capsule_point(output logic [2:0][31:0] pt);
    logic [32:0] t;
    logic [31:0] span, base;
    longint      mid;
    int          pick, i;
    t    = 33'(mesh_r) + 33'(probe_r);
    span = (t > 33'h3FFFFFFF) ? 32'h3FFFFFFF : t[31:0] + 32'd1;
    pick = $urandom_range(0, 2);
    for (i = 0; i < 3; i++) begin
      mid = (longint'($signed(seg_s[i])) + longint'($signed(seg_e[i]))) >>> 1;
      case (pick)
        0:       base = seg_s[i];
        1:       base = seg_e[i];
        default: base = 32'(mid);
      endcase
      pt[i] = base + 32'($urandom_range(0, 2 * span)) - span;
    end
    if ($urandom_range(0, 7) == 0) pt = {32'($urandom), 32'($urandom), 32'($urandom)};
  endtask

  task automatic send_random_batch(int count);
    logic [2:0][31:0] pt;
    int               i;
    for (i = 0; i < count; i++) begin
      near_capsule_point(pt);
      send_triangle(pt[0], pt[1], pt[2], IDX_W'($urandom),
                    (i == count - 1) || ($urandom_range(0, 15) == 0));
    end
    wait_results_done();
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Registers at reset: zero radius, zero-length segment at the origin
  task automatic test_reset_state();
    send_triangle(32'h0, 32'h0, 32'h0, 16'h0000, 1'b0);
    send_triangle(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hFFFF, 1'b1);
    send_triangle(32'h80000000, 32'h80000000, 32'h80000000, 16'h8001, 1'b0);
    wait_results_done();
  endtask

  // Segment along x from -4 to +4 with T = 1.5: every clamp region, the
  // exact threshold (not kept) and the coordinate extremes
  task automatic test_axis_cases();
    load_query(32'h10000, 32'h8000, 32'hFFFC0000, 32'h0, 32'h0,
               32'h40000, 32'h0, 32'h0);
    send_triangle(32'h0, 32'h10000, 32'h0, 16'h0001, 1'b0);       // interior, inside
    send_triangle(32'h0, 32'h18000, 32'h0, 16'h0002, 1'b0);       // interior, on surface
    send_triangle(32'hFFFB0000, 32'h0, 32'h0, 16'hA5A5, 1'b0);    // before start
    send_triangle(32'h58000, 32'h0, 32'h0, 16'h5A5A, 1'b1);       // past end, on surface
    send_triangle(32'h0, 32'h0, 32'h0, 16'h0000, 1'b0);           // on the axis
    send_triangle(32'h0, 32'h0, 32'h17FFF, 16'hFFFF, 1'b0);       // just inside
    send_triangle(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'h7FFF, 1'b0);
    send_triangle(32'h80000000, 32'h80000000, 32'h80000000, 16'h8000, 1'b1);
    wait_results_done();
  endtask

  // Mesh bound exactly touching the capsule passes; one step farther fails
  task automatic test_mesh_touch();
    load_query(32'h10000, 32'h8000, 32'hFFFC0000, 32'h18000, 32'h0,
               32'h40000, 32'h18000, 32'h0);
    send_triangle(32'h0, 32'h18000, 32'h0, 16'h0101, 1'b0);
    send_triangle(32'h0, 32'h30000, 32'h0, 16'h0202, 1'b1);
    wait_results_done();
    write_reg(REG_START_Y, 32'h18001);
    write_reg(REG_END_Y, 32'h18001);
    cfg_wr_en <= 1'b0;
    send_triangle(32'h0, 32'h18001, 32'h0, 16'h0303, 1'b1);
    wait_results_done();
  endtask

  // Squared length just below the short-segment bound collapses to the start
  // point; just above it the segment stays a segment
  task automatic test_short_segment();
    load_query(32'h20000, 32'h0, 32'h10000, 32'h0, 32'h0,
               32'h10000 + 32'd65, 32'h0, 32'h0);
    send_triangle(32'h10000 + 32'h20000 + 32'd30, 32'h0, 32'h0, 16'h1111, 1'b0);
    send_triangle(32'h10000, 32'h1FFFF, 32'h0, 16'h2222, 1'b1);
    wait_results_done();
    write_reg(REG_END_X, 32'h10000 + 32'd66);
    cfg_wr_en <= 1'b0;
    send_triangle(32'h10000 + 32'h20000 + 32'd30, 32'h0, 32'h0, 16'h3333, 1'b1);
    wait_results_done();
  endtask

  // Largest radii (top bit of the write dropped) and a corner-to-corner axis
  task automatic test_extreme_query();
    load_query(32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
               32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    send_triangle(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 16'hC3C3, 1'b0);
    send_triangle(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h3C3C, 1'b0);
    send_triangle(32'h7FFFFFFF, 32'h80000000, 32'h0, 16'hFFFE, 1'b1);
    wait_results_done();
  endtask

  task automatic test_random_queries(int n_queries, int per_query);
    int q;
    for (q = 0; q < n_queries; q++) begin
      randomize_query();
      send_random_batch(per_query);
    end
  endtask

  // Receiver holds off for a long stretch while the sender keeps offering,
  // so the pipeline fills and in_tready must drop
  task automatic test_backpressure();
    randomize_query();
    tx_gaps_on = 1'b0;
    hold_token <= hold_token + 1;
    send_random_batch(80);
    tx_gaps_on = 1'b1;
  endtask

  // Back-to-back transfers on both sides
  task automatic test_full_rate();
    randomize_query();
    tx_gaps_on   = 1'b0;
    rx_stalls_on = 1'b0;
    send_random_batch(80);
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    rst_n      <= 1'b0;
    cfg_wr_en  <= 1'b0;
    cfg_index  <= REG_MESH_RADIUS;
    cfg_wdata  <= '0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tlast   <= 1'b0;
    hold_token <= 0;
    tx_gaps_on   = 1'b1;
    rx_stalls_on = 1'b1;
    mismatch_count = 0;
    cycle_count    = 0;
    mesh_r  = '0;
    probe_r = '0;
    seg_s   = '0;
    seg_e   = '0;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_state();
    test_axis_cases();
    test_mesh_touch();
    test_short_segment();
    test_extreme_query();
    test_random_queries(10, 75);
    test_backpressure();
    test_full_rate();

    // every owed result is back; idle a while to catch any stray one
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0 && verdict_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
